// File: rtl/dds_command_word_formatter_assert.svh
`ifndef DDS_COMMAND_WORD_FORMATTER_ASSERT_SVH
`define DDS_COMMAND_WORD_FORMATTER_ASSERT_SVH

// same-cycle implication, quiet while in reset
`define DCWF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dcwf check failed");

// next-cycle implication, quiet while in reset
`define DCWF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dcwf check failed");

// next-cycle implication, also checked across reset
`define DCWF_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("dcwf check failed");

`endif

// File: rtl/dcwf_pkg.sv
`timescale 1ns / 1ps

package dcwf_pkg;

  localparam int unsigned CmdW      = 4;
  localparam int unsigned InFreqW   = 32;
  localparam int unsigned PhaseInW  = 16;
  localparam int unsigned WordW     = 16;
  localparam int unsigned FreqW     = 24;
  localparam int unsigned MultW     = 28;
  localparam int unsigned PhaseW    = 9;
  localparam int unsigned TwW       = 28;
  localparam int unsigned ProdW     = InFreqW + MultW;
  localparam int unsigned PqW       = 12;
  localparam int unsigned PhProdW   = 28;
  localparam int unsigned InDataW   = 64;
  localparam int unsigned OutDataW  = 104;
  localparam int unsigned CfgDataW  = 28;

  localparam logic [WordW-1:0]   WORD_FREQ_CTRL   = 16'h2100;
  localparam logic [WordW-1:0]   TAG_FREQ0        = 16'h4000;
  localparam logic [WordW-1:0]   TAG_FREQ1        = 16'h8000;
  localparam logic [WordW-1:0]   TAG_PHASE0       = 16'hC000;
  localparam logic [WordW-1:0]   TAG_PHASE1       = 16'hE000;
  localparam logic [WordW-1:0]   CTRL_RESET       = 16'h2000;
  localparam logic [TwW-1:0]     TW_MAX           = 28'hFFF_FFFF;
  localparam logic [PhaseInW-1:0] PHASE_MAX       = 16'd359;
  // ceil(2^24 / 45), exact floor for phase * 512 / 45 over 0..359
  localparam logic [18:0]        PHASE_RECIP      = 19'd372828;
  localparam int unsigned        PhaseShift       = 15;
  localparam logic [FreqW-1:0]   FREQ_LIMIT_RESET = 24'd12500000;
  localparam logic [MultW-1:0]   FREQ_MULT_RESET  = 28'd180143985;

  typedef enum logic [CmdW-1:0] {
    CMD_RAW      = 4'd0,
    CMD_RESET    = 4'd1,
    CMD_START    = 4'd2,
    CMD_START_F0 = 4'd3,
    CMD_START_F1 = 4'd4,
    CMD_SEL_F0   = 4'd5,
    CMD_SEL_F1   = 4'd6,
    CMD_SEL_P0   = 4'd7,
    CMD_SEL_P1   = 4'd8,
    CMD_SINE     = 4'd9,
    CMD_SQUARE   = 4'd10,
    CMD_TRIANGLE = 4'd11,
    CMD_SET_F0   = 4'd12,
    CMD_SET_F1   = 4'd13,
    CMD_SET_P0   = 4'd14,
    CMD_SET_P1   = 4'd15
  } cmd_t;

  typedef enum logic {
    CFG_FREQ_LIMIT = 1'b0,
    CFG_FREQ_MULT  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [WordW-1:0]  ctrl;
    logic [FreqW-1:0]  freq0;
    logic [FreqW-1:0]  freq1;
    logic [PhaseW-1:0] phase0;
    logic [PhaseW-1:0] phase1;
  } copies_t;

  typedef struct packed {
    logic              three;
    logic              status;
    logic [WordW-1:0]  w0;
    logic [WordW-1:0]  w1;
    logic [WordW-1:0]  w2;
    copies_t           copies;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_push_t;

  function automatic logic [WordW-1:0] ctrl_next(cmd_t cmd, logic [WordW-1:0] shadow,
                                                 logic [WordW-1:0] cw);
    logic [WordW-1:0] mask;
    logic [WordW-1:0] val;
    mask = 16'hFFFF;
    val  = 16'h0000;
    unique case (cmd)
      CMD_RAW:      begin mask = 16'h0000; val = cw;       end
      CMD_RESET:    begin mask = 16'hFEFF; val = 16'h0100; end
      CMD_START:    begin mask = 16'hFEFF; val = 16'h2000; end
      CMD_START_F0: begin mask = 16'hD6FF; val = 16'h2000; end
      CMD_START_F1: begin mask = 16'hD6FF; val = 16'h2800; end
      CMD_SEL_F0:   begin mask = 16'hF7FF; val = 16'h0000; end
      CMD_SEL_F1:   begin mask = 16'hF7FF; val = 16'h0800; end
      CMD_SEL_P0:   begin mask = 16'hFBFF; val = 16'h0000; end
      CMD_SEL_P1:   begin mask = 16'hFBFF; val = 16'h0400; end
      CMD_SINE:     begin mask = 16'hFFD5; val = 16'h0000; end
      CMD_SQUARE:   begin mask = 16'hFFD5; val = 16'h0028; end
      CMD_TRIANGLE: begin mask = 16'hFFD5; val = 16'h0002; end
      default:      begin mask = 16'hFFFF; val = 16'h0000; end
    endcase
    return (shadow & mask) | val;
  endfunction

endpackage

// File: rtl/dds_command_word_formatter.sv
`timescale 1ns / 1ps
// channel   dir  handshake            content
// in_       in   in_tvalid/in_tready  command request: cmd, frequency, phase, raw word
// out_      out  out_tvalid/out_tready serial words with shadow copies, last, status
// cfg_      in   cfg_we               freq_limit (index 0), freq_mult (index 1)
//
// a request is taken every cycle while the four-entry queue has room
// in-range frequency sets give three words, other requests one, a bad phase none
// output runs at one word per cycle while out_tready is high, so a frequency set takes the output for three words
// first word passes through the multiply stage, the queue and the output register
// synchronous active-low reset; shadows return to their reset values, queue empties
// a stalled output fills the queue, then in_tready drops

module dds_command_word_formatter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // frequency[31:0], phase_deg[47:32], control_word[63:48]
  input  logic [dcwf_pkg::InDataW-1:0]      in_tdata,
  // cmd[3:0]
  input  logic [dcwf_pkg::CmdW-1:0]         in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // spi_word[15:0], ctrl_copy[31:16], freq0_copy[55:32], freq1_copy[79:56],
  // phase0_copy[88:80], phase1_copy[97:89], zero fill[103:98]
  output logic [dcwf_pkg::OutDataW-1:0]     out_tdata,
  output logic                              out_tlast,
  // status[0]
  output logic                              out_tuser,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [dcwf_pkg::CfgDataW-1:0]     cfg_wdata
);

  dcwf_pkg::q_push_t push;
  dcwf_pkg::entry_t  head;
  logic              q_full;
  logic              head_valid;
  logic              pop;

  dcwf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .q_full    (q_full)
  );

  dcwf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .q_full     (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  dcwf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// File: rtl/dcwf_front.sv
`timescale 1ns / 1ps

module dcwf_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [dcwf_pkg::InDataW-1:0]        in_tdata,
  input  logic [dcwf_pkg::CmdW-1:0]           in_tuser,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [dcwf_pkg::CfgDataW-1:0]       cfg_wdata,
  output dcwf_pkg::q_push_t                   push,
  input  logic                                q_full
);

  localparam int unsigned TwW_OFS = 24;
  localparam int unsigned PhaseShift_HI = dcwf_pkg::PhaseShift + dcwf_pkg::PqW - 1;

  logic [dcwf_pkg::FreqW-1:0]    freq_limit_r;
  logic [dcwf_pkg::MultW-1:0]    freq_mult_r;

  logic                          s1_valid_r;
  dcwf_pkg::cmd_t                s1_cmd_r;
  logic [dcwf_pkg::FreqW-1:0]    s1_freq_r;
  logic [dcwf_pkg::PhaseW-1:0]   s1_ph_r;
  logic [dcwf_pkg::WordW-1:0]    s1_cw_r;
  logic [dcwf_pkg::ProdW-1:0]    s1_prod_r;
  logic                          s1_frange_r;
  logic                          s1_prange_r;
  logic [dcwf_pkg::PqW-1:0]      s1_pq_r;

  dcwf_pkg::copies_t             shadow_r;
  dcwf_pkg::copies_t             shadow_nxt;

  logic [dcwf_pkg::InFreqW-1:0]  in_freq;
  logic [dcwf_pkg::PhaseInW-1:0] in_ph;
  logic [dcwf_pkg::WordW-1:0]    in_cw;
  logic [dcwf_pkg::PhProdW-1:0]  ph_prod;
  logic [dcwf_pkg::ProdW-TwW_OFS-1:0] tw_full;
  logic [dcwf_pkg::TwW-1:0]      tw;
  logic                          accept;
  logic                          advance;
  logic                          drop;
  dcwf_pkg::entry_t              entry;

  assign in_freq = in_tdata[31:0];
  assign in_ph   = in_tdata[47:32];
  assign in_cw   = in_tdata[63:48];

  assign advance   = s1_valid_r && !q_full;
  assign in_tready = !s1_valid_r || !q_full;
  assign accept    = in_tvalid && in_tready;
  assign ph_prod   = dcwf_pkg::PhProdW'(in_ph[dcwf_pkg::PhaseW-1:0]) *
                     dcwf_pkg::PhProdW'(dcwf_pkg::PHASE_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_limit_r <= dcwf_pkg::FREQ_LIMIT_RESET;
      freq_mult_r  <= dcwf_pkg::FREQ_MULT_RESET;
    end else if (cfg_we) begin
      unique case (dcwf_pkg::cfg_idx_t'(cfg_index))
        dcwf_pkg::CFG_FREQ_LIMIT: freq_limit_r <= cfg_wdata[dcwf_pkg::FreqW-1:0];
        dcwf_pkg::CFG_FREQ_MULT:  freq_mult_r  <= cfg_wdata[dcwf_pkg::MultW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd_r    <= dcwf_pkg::cmd_t'(in_tuser);
      s1_freq_r   <= in_freq[dcwf_pkg::FreqW-1:0];
      s1_ph_r     <= in_ph[dcwf_pkg::PhaseW-1:0];
      s1_cw_r     <= in_cw;
      s1_prod_r   <= dcwf_pkg::ProdW'(in_freq) * dcwf_pkg::ProdW'(freq_mult_r);
      s1_frange_r <= in_freq <= dcwf_pkg::InFreqW'(freq_limit_r);
      s1_prange_r <= in_ph <= dcwf_pkg::PHASE_MAX;
      s1_pq_r     <= ph_prod[PhaseShift_HI:dcwf_pkg::PhaseShift];
    end
  end

  // tuning word, saturated to 28 bits
  assign tw_full = s1_prod_r[dcwf_pkg::ProdW-1:TwW_OFS];
  assign tw = (|tw_full[dcwf_pkg::ProdW-TwW_OFS-1:dcwf_pkg::TwW]) ? dcwf_pkg::TW_MAX :
              tw_full[dcwf_pkg::TwW-1:0];

  always_comb begin
    logic [dcwf_pkg::WordW-1:0] tag;
    tag          = dcwf_pkg::TAG_FREQ0;
    shadow_nxt   = shadow_r;
    drop         = 1'b0;
    entry        = '0;
    unique case (s1_cmd_r)
      dcwf_pkg::CMD_SET_F0, dcwf_pkg::CMD_SET_F1: begin
        tag = (s1_cmd_r == dcwf_pkg::CMD_SET_F0) ? dcwf_pkg::TAG_FREQ0 : dcwf_pkg::TAG_FREQ1;
        entry.w0 = dcwf_pkg::WORD_FREQ_CTRL;
        if (s1_frange_r) begin
          entry.three = 1'b1;
          entry.w1    = tag | {2'b00, tw[13:0]};
          entry.w2    = tag | {2'b00, tw[27:14]};
          if (s1_cmd_r == dcwf_pkg::CMD_SET_F0) begin
            shadow_nxt.freq0 = s1_freq_r;
          end else begin
            shadow_nxt.freq1 = s1_freq_r;
          end
        end else begin
          entry.status = 1'b1;
        end
      end
      dcwf_pkg::CMD_SET_P0, dcwf_pkg::CMD_SET_P1: begin
        tag = (s1_cmd_r == dcwf_pkg::CMD_SET_P0) ? dcwf_pkg::TAG_PHASE0 :
              dcwf_pkg::TAG_PHASE1;
        entry.w0 = tag | {4'b0000, s1_pq_r};
        if (s1_prange_r) begin
          if (s1_cmd_r == dcwf_pkg::CMD_SET_P0) begin
            shadow_nxt.phase0 = s1_ph_r;
          end else begin
            shadow_nxt.phase1 = s1_ph_r;
          end
        end else begin
          drop = 1'b1;
        end
      end
      default: begin
        shadow_nxt.ctrl = dcwf_pkg::ctrl_next(s1_cmd_r, shadow_r.ctrl, s1_cw_r);
        entry.w0        = shadow_nxt.ctrl;
      end
    endcase
    entry.copies = shadow_nxt;
  end

  assign push.valid = advance && !drop;
  assign push.entry = entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shadow_r <= '{ctrl: dcwf_pkg::CTRL_RESET, freq0: '0, freq1: '0, phase0: '0,
                    phase1: '0};
    end else if (advance) begin
      shadow_r <= shadow_nxt;
    end
  end

endmodule

// File: rtl/dcwf_queue.sv
`timescale 1ns / 1ps

module dcwf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  dcwf_pkg::q_push_t push,
  output logic              q_full,
  input  logic              pop,
  output logic              head_valid,
  output dcwf_pkg::entry_t  head
);

  localparam int unsigned Depth = 4;
  localparam int unsigned Aw    = $clog2(Depth);

  dcwf_pkg::entry_t mem_r [Depth];
  logic [Aw-1:0]    wptr_r;
  logic [Aw-1:0]    rptr_r;
  logic [Aw:0]      count_r;
  logic             do_push;
  logic             do_pop;

  assign q_full     = count_r == (Aw+1)'(Depth);
  assign head_valid = count_r != '0;
  assign head       = mem_r[rptr_r];
  assign do_push    = push.valid && !q_full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push.entry;
    end
  end

endmodule

// File: rtl/dcwf_back.sv
`timescale 1ns / 1ps

module dcwf_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            head_valid,
  input  dcwf_pkg::entry_t                head,
  output logic                            pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [dcwf_pkg::OutDataW-1:0]   out_tdata,
  output logic                            out_tlast,
  output logic                            out_tuser
);

  logic [1:0]                 cnt_r;
  logic                       out_tvalid_r;
  logic [dcwf_pkg::OutDataW-1:0] out_tdata_r;
  logic                       out_tlast_r;
  logic                       out_tuser_r;
  logic                       load;
  logic                       is_last;
  logic [dcwf_pkg::WordW-1:0] word;

  assign load    = head_valid && (!out_tvalid_r || out_tready);
  assign is_last = !head.three || (cnt_r == 2'd2);
  assign pop     = load && is_last;

  always_comb begin
    unique case (cnt_r)
      2'd1:    word = head.w1;
      2'd2:    word = head.w2;
      default: word = head.w0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
      cnt_r        <= '0;
    end else if (load) begin
      out_tvalid_r <= 1'b1;
      cnt_r        <= is_last ? 2'd0 : cnt_r + 2'd1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tdata_r <= {6'b0, head.copies.phase1, head.copies.phase0, head.copies.freq1,
                      head.copies.freq0, head.copies.ctrl, word};
      out_tlast_r <= is_last;
      out_tuser_r <= head.status;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tuser  = out_tuser_r;

endmodule

// File: rtl/dcwf_checker.sv
`timescale 1ns / 1ps
`include "dds_command_word_formatter_assert.svh"

module dcwf_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [dcwf_pkg::OutDataW-1:0]   out_tdata,
  input logic                            out_tlast,
  input logic                            out_tuser
);

  // stalled word holds
  `DCWF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // range error is a single word
  `DCWF_ASSERT_NOW(a_err_last, out_tvalid && out_tuser, out_tlast)

  // range error only on the frequency control word
  `DCWF_ASSERT_NOW(a_err_word, out_tvalid && out_tuser,
                   out_tdata[15:0] == dcwf_pkg::WORD_FREQ_CTRL)

  // reset empties the output
  `DCWF_ASSERT_NEXT_ALWAYS(a_rst_idle, !rst_n, !out_tvalid)

endmodule

bind dds_command_word_formatter dcwf_checker u_dcwf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
